@@ rtl/jsc_pkg.sv @@
// jsc_pkg: shared types, constants and helpers of the joystick sample classifier
// no dependencies; imported by every module of the block

package jsc_pkg;

  // configuration register indexes
  localparam logic REG_DEADZONE = 1'b0;
  localparam logic REG_MOVE_THR = 1'b1;

  localparam logic [14:0] DEADZONE_RESET = 15'd8191;
  localparam logic [14:0] MOVE_THR_RESET = 15'd128;

  // full scale and the 95 percent edge level, 32767 * 95 / 100 truncated
  localparam logic [15:0] AXIS_FULL  = 16'd32767;
  localparam logic [15:0] EDGE_LEVEL = 16'd31128;
  localparam logic [7:0]  MAG_CLAMP  = 8'd142;

  // first bit weight of the square root
  localparam logic [30:0] ROOT_FIRST_BIT = 31'h4000_0000;

  // stick class codes
  localparam logic [2:0] CLS_CENTRE   = 3'd0;
  localparam logic [2:0] CLS_DEADZONE = 3'd1;
  localparam logic [2:0] CLS_SNAP_X   = 3'd2;
  localparam logic [2:0] CLS_SNAP_Y   = 3'd3;
  localparam logic [2:0] CLS_DIAGONAL = 3'd4;
  localparam logic [2:0] CLS_EDGE     = 3'd5;
  localparam logic [2:0] CLS_ACTIVE   = 3'd6;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
  } in_word_t;

  typedef struct packed {
    logic signed [7:0] x_percent;
    logic signed [7:0] y_percent;
    logic [7:0]        magnitude_percent;
    logic [2:0]        stick_class;
    logic [6:0]        peak_x_percent;
    logic [6:0]        peak_y_percent;
  } out_word_t;

  // queue status seen by the back part
  typedef struct packed {
    logic     empty;
    in_word_t head;
  } queue_stat_t;

  // n / 32767 for n below 2^23: shift by 15, then one correction step
  function automatic logic [7:0] pct_of(input logic [22:0] n);
    logic [7:0]  q0;
    logic [15:0] r;
    q0 = n[22:15];
    r  = {1'b0, n[14:0]} + {8'd0, q0};
    return (r >= AXIS_FULL) ? q0 + 8'd1 : q0;
  endfunction

endpackage

@@ rtl/joystick_sample_classifier_core.sv @@
// joystick_sample_classifier_core: top level with configuration registers
// a moving sample is queued; the back part pops it, squares, sums and takes the root,
// then loads the result once the output is free; one word at a time, root loop of 16 steps
// samples that do not move are taken while the queue is not full and give no word
// reset: asynchronous active low; position and peaks clear, registers take defaults
// depends on jsc_pkg, jsc_front, jsc_queue and jsc_back

module joystick_sample_classifier_core import jsc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [14:0] cfg_data_i
);

  logic [14:0] deadzone_q;
  logic [14:0] move_thr_q;
  logic        push;
  in_word_t    push_word;
  logic        pop;
  logic        queue_full;
  queue_stat_t queue_stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= DEADZONE_RESET;
      move_thr_q <= MOVE_THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEADZONE: deadzone_q <= cfg_data_i;
        REG_MOVE_THR: move_thr_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  jsc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .move_thr_i   (move_thr_q),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_word_o  (push_word)
  );

  jsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .full_o      (queue_full),
    .stat_o      (queue_stat)
  );

  jsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .deadzone_i  (deadzone_q),
    .queue_i     (queue_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ rtl/jsc_queue.sv @@
// jsc_queue: small register queue of accepted stick words between front and back
// depends on jsc_pkg for the word and status types

module jsc_queue import jsc_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  in_word_t    push_word_i,
  input  logic        pop_i,
  output logic        full_o,
  output queue_stat_t stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  in_word_t      mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o       = (count_q == FULL_CNT);
  assign stat_o.empty = (count_q == '0);
  assign stat_o.head  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

@@ rtl/jsc_front.sv @@
// jsc_front: input handshake and move filter against the last accepted position
// depends on jsc_pkg for the input word type

module jsc_front import jsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  input  logic [14:0] move_thr_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output in_word_t    push_word_o
);

  logic signed [15:0] last_x_q, last_y_q;
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic               moved;

  // per-axis distance from the last accepted position
  always_comb begin
    dx    = 17'(in_word_i.axis_x) - 17'(last_x_q);
    dy    = 17'(in_word_i.axis_y) - 17'(last_y_q);
    adx   = dx[16] ? 17'(-dx) : 17'(dx);
    ady   = dy[16] ? 17'(-dy) : 17'(dy);
    moved = (adx >= {2'b00, move_thr_i}) || (ady >= {2'b00, move_thr_i});
  end

  assign in_stall_o  = queue_full_i;
  assign push_o      = in_valid_i && !queue_full_i && moved;
  assign push_word_o = in_word_i;

  // last accepted position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q <= '0;
      last_y_q <= '0;
    end else if (push_o) begin
      last_x_q <= in_word_i.axis_x;
      last_y_q <= in_word_i.axis_y;
    end
  end

endmodule

@@ rtl/jsc_back.sv @@
// jsc_back: squares, iterative square root, percentages, class and peaks
// depends on jsc_pkg for word types, class codes and the percent helper

module jsc_back import jsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [14:0] deadzone_i,
  input  queue_stat_t queue_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQR  = 5'b00010,
    S_SUM  = 5'b00100,
    S_ROOT = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [15:0] ax_q, ay_q;
  logic        x_neg_q, y_neg_q;
  logic [31:0] sqx_q, sqy_q;
  logic [31:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [30:0] bit_q, bit_d;
  logic [6:0]  peak_x_q, peak_x_d;
  logic [6:0]  peak_y_q, peak_y_d;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_word_q, out_word_d;

  logic [31:0] trial;
  logic [15:0] ax_in, ay_in;
  logic [15:0] mag;
  logic [7:0]  pxa, pya, mpct;
  logic [15:0] mx, diff;
  logic [2:0]  cls;
  logic        out_free;

  // absolute values of the queue head
  always_comb begin
    ax_in = queue_i.head.axis_x[15] ? 16'(-queue_i.head.axis_x) : 16'(queue_i.head.axis_x);
    ay_in = queue_i.head.axis_y[15] ? 16'(-queue_i.head.axis_y) : 16'(queue_i.head.axis_y);
  end

  // percentages and classification of the finished root
  always_comb begin
    mag  = root_q[15:0];
    pxa  = pct_of(23'({7'd0, ax_q} * 23'd100));
    pya  = pct_of(23'({7'd0, ay_q} * 23'd100));
    mpct = pct_of(23'({7'd0, mag} * 23'd100));
    if (mpct > MAG_CLAMP) begin
      mpct = MAG_CLAMP;
    end
    mx   = (ax_q > ay_q) ? ax_q : ay_q;
    diff = (ax_q > ay_q) ? ax_q - ay_q : ay_q - ax_q;
    if ({3'd0, deadzone_i} >= 18'({2'd0, mag} * 18'd3)) begin
      cls = CLS_CENTRE;
    end else if (mag <= {1'b0, deadzone_i}) begin
      cls = CLS_DEADZONE;
    end else if (ax_q > {deadzone_i, 1'b0} && ay_q <= (ax_q >> 3)) begin
      cls = CLS_SNAP_X;
    end else if (ay_q > {deadzone_i, 1'b0} && ax_q <= (ay_q >> 3)) begin
      cls = CLS_SNAP_Y;
    end else if (ax_q > {1'b0, deadzone_i} && ay_q > {1'b0, deadzone_i} &&
                 19'({3'd0, diff} * 19'd5) <= {3'd0, mx}) begin
      cls = CLS_DIAGONAL;
    end else if (mx >= EDGE_LEVEL) begin
      cls = CLS_EDGE;
    end else begin
      cls = CLS_ACTIVE;
    end
  end

  assign trial    = root_q + {1'b0, bit_q};
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == S_IDLE) && !queue_i.empty;

  // sequencer
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    root_d      = root_q;
    bit_d       = bit_q;
    peak_x_d    = peak_x_q;
    peak_y_d    = peak_y_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    case (state_q)
      S_IDLE: begin
        if (!queue_i.empty) begin
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        rem_d   = sqx_q + sqy_q;
        root_d  = '0;
        bit_d   = ROOT_FIRST_BIT;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        // one result bit a cycle
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          root_d = (root_q >> 1) + {1'b0, bit_q};
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // load the output register once it is free
        if (out_free) begin
          if (pxa[6:0] > peak_x_q) begin
            peak_x_d = pxa[6:0];
          end
          if (pya[6:0] > peak_y_q) begin
            peak_y_d = pya[6:0];
          end
          out_valid_d                  = 1'b1;
          out_word_d.x_percent         = x_neg_q ? 8'(-pxa) : pxa;
          out_word_d.y_percent         = y_neg_q ? 8'(-pya) : pya;
          out_word_d.magnitude_percent = mpct;
          out_word_d.stick_class       = cls;
          out_word_d.peak_x_percent    = peak_x_d;
          out_word_d.peak_y_percent    = peak_y_d;
          state_d                      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      peak_x_q    <= '0;
      peak_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      peak_x_q    <= peak_x_d;
      peak_y_q    <= peak_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ax_q    <= ax_in;
      ay_q    <= ay_in;
      x_neg_q <= queue_i.head.axis_x[15];
      y_neg_q <= queue_i.head.axis_y[15];
    end
    if (state_q == S_SQR) begin
      sqx_q <= {16'd0, ax_q} * {16'd0, ax_q};
      sqy_q <= {16'd0, ay_q} * {16'd0, ay_q};
    end
    rem_q      <= rem_d;
    root_q     <= root_d;
    bit_q      <= bit_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ verif/joystick_sample_classifier_core_tb.sv @@
// joystick_sample_classifier_core_tb: self-checking bench for the stick sample classifier
// drives sample words and register writes, predicts each result word and checks every field
// depends on jsc_pkg and joystick_sample_classifier_core

module joystick_sample_classifier_core_tb import jsc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL_SCALE     = 32767;
  localparam int EDGE_RAW       = FULL_SCALE * 95 / 100;
  localparam int MAG_LIMIT      = 142;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_WAIT       = 8;
  localparam int REPORT_LIMIT   = 10;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_word   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_we    = 1'b0;
  logic        cfg_idx   = REG_DEADZONE;
  logic [14:0] cfg_data  = '0;

  joystick_sample_classifier_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block state and registers
  int pos_x         = 0;
  int pos_y         = 0;
  int peak_x        = 0;
  int peak_y        = 0;
  int deadzone_cfg  = DEADZONE_RESET;
  int threshold_cfg = MOVE_THR_RESET;

  out_word_t expected_q[$];
  int        mismatches  = 0;
  int        hold_cycles = 0;
  int        idle_cycles = 0;
  bit        send_idle   = 1'b1;
  bit        recv_idle   = 1'b1;

  // directed probe rows, some with a hand-written result
  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t result;
  } probe_row_t;

  probe_row_t probe_rows[$];

  function automatic int abs_val(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int bound_int(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // percent of full scale, truncated toward zero
  function automatic int scale_pct(input int v);
    return bound_int(v * 100 / FULL_SCALE, -100, 100);
  endfunction

  // floor square root, one result bit per pass
  function automatic int int_sqrt(input longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root + (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return int'(root);
  endfunction

  // class code, first matching rule wins
  function automatic logic [2:0] sort_class(input int ax, input int ay, input int mag);
    int dz;
    int mx;
    int df;
    dz = deadzone_cfg;
    mx = (ax > ay) ? ax : ay;
    df = (ax > ay) ? ax - ay : ay - ax;
    if (mag <= dz / 3) return CLS_CENTRE;
    if (mag <= dz) return CLS_DEADZONE;
    if (ax > 2 * dz && ay <= ax / 8) return CLS_SNAP_X;
    if (ay > 2 * dz && ax <= ay / 8) return CLS_SNAP_Y;
    if (ax > dz && ay > dz && df <= mx / 5) return CLS_DIAGONAL;
    if (mx >= EDGE_RAW) return CLS_EDGE;
    return CLS_ACTIVE;
  endfunction

  // advances the shadow state; returns 1 with the result word when the stick moved
  function automatic bit predict_move(input in_word_t w, output out_word_t r);
    int x;
    int y;
    int ax;
    int ay;
    int mag;
    int xp;
    int yp;
    int mp;
    x = $signed(w.axis_x);
    y = $signed(w.axis_y);
    r = '0;
    if (abs_val(x - pos_x) < threshold_cfg && abs_val(y - pos_y) < threshold_cfg)
      return 1'b0;
    pos_x = x;
    pos_y = y;
    ax = abs_val(x);
    ay = abs_val(y);
    if (scale_pct(ax) > peak_x) peak_x = scale_pct(ax);
    if (scale_pct(ay) > peak_y) peak_y = scale_pct(ay);
    xp  = scale_pct(x);
    yp  = scale_pct(y);
    mag = int_sqrt(longint'(ax) * ax + longint'(ay) * ay);
    mp  = bound_int(mag * 100 / FULL_SCALE, 0, MAG_LIMIT);
    r.x_percent         = xp[7:0];
    r.y_percent         = yp[7:0];
    r.magnitude_percent = mp[7:0];
    r.stick_class       = sort_class(ax, ay, mag);
    r.peak_x_percent    = peak_x[6:0];
    r.peak_y_percent    = peak_y[6:0];
    return 1'b1;
  endfunction

  function automatic void add_probe(input int x, input int y);
    probe_row_t row;
    row.word.axis_x = x[15:0];
    row.word.axis_y = y[15:0];
    row.typed       = 1'b0;
    row.result      = '0;
    probe_rows.push_back(row);
  endfunction

  function automatic void add_known(input int x, input int y, input int xp, input int yp,
                                    input int mp, input logic [2:0] cls,
                                    input int pkx, input int pky);
    probe_row_t row;
    row.word.axis_x                = x[15:0];
    row.word.axis_y                = y[15:0];
    row.typed                      = 1'b1;
    row.result.x_percent           = xp[7:0];
    row.result.y_percent           = yp[7:0];
    row.result.magnitude_percent   = mp[7:0];
    row.result.stick_class         = cls;
    row.result.peak_x_percent      = pkx[6:0];
    row.result.peak_y_percent      = pky[6:0];
    probe_rows.push_back(row);
  endfunction

  // move from p by d in a random direction, falling back to the far extreme
  function automatic int step_from(input int p, input int d);
    if ($urandom_range(0, 1) && p + d <= 32767) return p + d;
    if (p - d >= -32768) return p - d;
    if (p + d <= 32767) return p + d;
    return (p >= 0) ? -32768 : 32767;
  endfunction

  function automatic int nudge(input int p, input int span);
    return bound_int(p + $urandom_range(0, 2 * span) - span, -32768, 32767);
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  // random sample word, mostly moves shaped around the thresholds and class borders
  function automatic in_word_t make_sample();
    int x;
    int y;
    int thr;
    int base;
    int other;
    in_word_t w;
    x = pos_x;
    y = pos_y;
    thr = threshold_cfg;
    case ($urandom_range(0, 11))
      0, 1: begin
        return in_word_t'($urandom);
      end
      2, 3: begin
        if ($urandom_range(0, 1)) begin
          x = step_from(pos_x, thr + $urandom_range(0, 64));
          y = nudge(pos_y, 32);
        end else begin
          y = step_from(pos_y, thr + $urandom_range(0, 64));
          x = nudge(pos_x, 32);
        end
      end
      4: begin
        if ($urandom_range(0, 1)) x = step_from(pos_x, thr);
        else y = step_from(pos_y, thr);
      end
      5: begin
        x = step_from(pos_x, (thr > 0) ? thr - 1 : 0);
        y = step_from(pos_y, (thr > 0) ? thr - 1 : 0);
      end
      6: begin
        x = pick_extreme();
        y = pick_extreme();
      end
      7, 8, 9: begin
        case ($urandom_range(0, 4))
          0: base = deadzone_cfg / 3;
          1: base = deadzone_cfg;
          2: base = 2 * deadzone_cfg;
          3: base = EDGE_RAW;
          default: base = $urandom_range(0, FULL_SCALE);
        endcase
        base = bound_int(nudge(bound_int(base, 0, FULL_SCALE), 2), 0, FULL_SCALE);
        case ($urandom_range(0, 3))
          0: other = base / 8;
          1: other = base - base / 5;
          2: other = base;
          default: other = $urandom_range(0, base);
        endcase
        other = bound_int(nudge(other, 1), 0, FULL_SCALE);
        if ($urandom_range(0, 1)) base = -base;
        if ($urandom_range(0, 1)) other = -other;
        if ($urandom_range(0, 1)) begin
          x = base;
          y = other;
        end else begin
          x = other;
          y = base;
        end
      end
      10: ;
      default: begin
        x = nudge(pos_x, 3);
        y = nudge(pos_y, 3);
      end
    endcase
    w.axis_x = x[15:0];
    w.axis_y = y[15:0];
    return w;
  endfunction

  function automatic void report_word(input string what, input out_word_t e,
                                      input out_word_t g);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t %s: expected x %0d y %0d mag %0d class %0d peaks %0d/%0d", $time, what,
               e.x_percent, e.y_percent, e.magnitude_percent, e.stick_class,
               e.peak_x_percent, e.peak_y_percent,
               " got x %0d y %0d mag %0d class %0d peaks %0d/%0d",
               g.x_percent, g.y_percent, g.magnitude_percent, g.stick_class,
               g.peak_x_percent, g.peak_y_percent);
  endfunction

  // present one sample word after a random gap and wait for it to be taken
  task automatic drive_sample(input in_word_t w, input bit typed, input out_word_t known);
    int gap;
    out_word_t pred;
    gap = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) begin
        in_word = in_word_t'($urandom);
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_word  = w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_move(w, pred)) begin
      expected_q.push_back(typed ? known : pred);
    end
    @(negedge clk);
  endtask

  // hold off until every expected word is back and the block is quiet
  task automatic settle_idle();
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [14:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_DEADZONE) deadzone_cfg = val;
    else threshold_cfg = val;
  endtask

  // one register setting, then a fixed count of random words
  task automatic run_phase(input logic [14:0] dz, input logic [14:0] thr, input int target);
    int items;
    settle_idle();
    write_reg(REG_DEADZONE, dz);
    write_reg(REG_MOVE_THR, thr);
    items = 0;
    while (items < target) begin
      if (items % 50 == 0) begin
        send_idle = ($urandom_range(0, 2) != 0);
        recv_idle = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 199) == 0) settle_idle();
      drive_sample(make_sample(), 1'b0, '0);
      items++;
    end
  endtask

  // result word check against the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_word("unexpected word", '0, out_word);
      end else begin
        want = expected_q.pop_front();
        if (want.x_percent !== out_word.x_percent ||
            want.y_percent !== out_word.y_percent ||
            want.magnitude_percent !== out_word.magnitude_percent ||
            want.stick_class !== out_word.stick_class ||
            want.peak_x_percent !== out_word.peak_x_percent ||
            want.peak_y_percent !== out_word.peak_y_percent)
          report_word("word mismatch", want, out_word);
      end
      hold_cycles = recv_idle ? $urandom_range(0, MAX_WAIT) : 0;
    end
  end

  // receiver stall: drawn wait per word, noise while nothing is offered
  always @(negedge clk) begin
    if (out_valid && hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else if (!out_valid && recv_idle) begin
      out_stall = ($urandom_range(0, 3) == 0);
    end else begin
      out_stall = 1'b0;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("joystick_sample_classifier_core_tb failed");
      $finish;
    end
  end

  // reset, directed probes at reset settings, then random phases
  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // from rest: first sample does not move
    add_probe(0, 0);
    // full scale on each axis, both signs
    add_known(32767, 0, 100, 0, 100, CLS_SNAP_X, 100, 0);
    add_known(-32768, 0, -100, 0, 100, CLS_SNAP_X, 100, 0);
    add_known(0, 32767, 0, 100, 100, CLS_SNAP_Y, 100, 100);
    add_known(0, -32768, 0, -100, 100, CLS_SNAP_Y, 100, 100);
    // corners, magnitude near its top, then back to centre
    add_known(-32768, -32768, -100, -100, 141, CLS_DIAGONAL, 100, 100);
    add_known(32767, 32767, 100, 100, 141, CLS_DIAGONAL, 100, 100);
    add_known(0, 0, 0, 0, 0, CLS_CENTRE, 100, 100);
    // under and exactly at the move threshold
    add_probe(100, 50);
    add_probe(128, 0);
    // one of each class but centre
    add_probe(5000, 0);
    add_probe(20000, 1000);
    add_probe(1000, -20000);
    add_probe(-12000, 11000);
    add_probe(31500, 20000);
    add_probe(15000, -5000);
    // edge level and just below it
    add_probe(-31128, -9000);
    add_probe(-31127, -8800);
    // truncation toward zero on small negatives
    add_probe(-1, 1);
    add_probe(-328, 0);
    // class borders: snap x, deadzone, centre
    add_probe(16383, 2047);
    add_probe(8191, 0);
    add_probe(2730, 0);
    add_probe(2731, 200);
    foreach (probe_rows[i])
      drive_sample(probe_rows[i].word, probe_rows[i].typed, probe_rows[i].result);

    run_phase(DEADZONE_RESET, MOVE_THR_RESET, 300);
    run_phase(15'd0, 15'd0, 250);
    run_phase(15'h7fff, 15'h7fff, 60);
    run_phase(15'd0, 15'd1, 250);
    run_phase(15'h7fff, 15'd1, 250);
    run_phase(15'($urandom), 15'($urandom_range(1, 512)), 250);
    run_phase(15'($urandom), 15'($urandom_range(0, 4000)), 250);
    settle_idle();

    mismatches += expected_q.size();
    if (mismatches == 0) begin
      $display("joystick_sample_classifier_core_tb passed");
    end else begin
      $display("joystick_sample_classifier_core_tb failed");
    end
    $finish;
  end

endmodule
